// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console wrap writer package
// Shared widths, character codes, command codes and controller states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int TEXT_SIZE_DEF = 16384;
  localparam int MAX_COLS_DEF  = 256;

  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 14;
  localparam int COL_W   = 8;
  localparam int CELL_W  = 9;
  localparam int LW_W    = 9;
  localparam int TL_W    = 15;
  localparam int CFG_W   = 15;
  localparam int CFGI_W  = 2;
  localparam int PROD_W  = ROW_W + LW_W;
  localparam int RING_MAX = 16384;

  localparam logic [LW_W-1:0]  LW_RST  = 9'd38;
  localparam logic [TL_W-1:0]  TL_RST  = 15'd431;
  localparam logic [ROW_W-1:0] ROW_RST = 14'd430;

  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_COLOR1 = 8'h01;
  localparam logic [CHAR_W-1:0] CH_COLOR2 = 8'h02;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE, CMD_READ, CMD_CLEAR, CMD_NONE
  } cmd_t;

  typedef enum logic [CFGI_W-1:0] {
    REG_LINE_WIDTH, REG_TOTAL_LINES, REG_OR_MASK, REG_NONE
  } reg_idx_t;

  typedef enum logic [1:0] {
    FC_PUT, FC_POST, FC_DONE
  } flush_cont_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ROWMOD, S_MODW, S_MUL,
    S_PC_ADJ, S_PC_BASE, S_PC_CLR, S_PC_CHAR,
    S_FL_START, S_FL_RD, S_FL_GET, S_FL_NEXT,
    S_HOLD, S_POST,
    S_RD_START, S_RD_ROW, S_RD_ADDR, S_RD_DATA,
    S_CLR
  } state_t;

endpackage

// ===== rtl/core/tcw_in_if.sv =====
// ----------------------------------------------------------------------------
// Text console input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic              last_of_message;
  logic [ROW_W-1:0]  line_back;
  logic [COL_W-1:0]  column;

  modport source (output valid, cmd, char_code, last_of_message, line_back, column,
                  input ready);
  modport sink   (input valid, cmd, char_code, last_of_message, line_back, column,
                  output ready);
endinterface

// ===== rtl/core/tcw_out_if.sv =====
// ----------------------------------------------------------------------------
// Text console result channel
// Valid/ready channel carrying one read cell.
// ----------------------------------------------------------------------------
interface tcw_out_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic              cell_valid;

  modport source (output valid, cell_value, cell_valid, input ready);
  modport sink   (input valid, cell_value, cell_valid, output ready);
endinterface

// ===== rtl/core/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/tcw_mod.sv =====
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring remainder, one dividend bit per cycle; done pulses when ready.
// ----------------------------------------------------------------------------
module tcw_mod #(
  parameter int NW  = 23,
  parameter int DVW = 17
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] rem
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    dvd_r;
  logic [DVW-1:0]   div_r;
  logic [DVW-1:0]   rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DVW:0]     trial;

  assign trial = {rem_r, dvd_r[NW-1]};
  assign done  = done_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(NW);
        dvd_r <= dividend;
        div_r <= divisor;
        rem_r <= '0;
      end else if (run_r) begin
        dvd_r <= {dvd_r[NW-2:0], 1'b0};
        if (trial >= {1'b0, div_r}) begin
          rem_r <= DVW'(trial - {1'b0, div_r});
        end else begin
          rem_r <= trial[DVW-1:0];
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/text_console_wrap_writer.sv =====
// ----------------------------------------------------------------------------
// Text console wrap writer
// Writes message bytes into a ring of text lines with word wrap, reads cells.
// ----------------------------------------------------------------------------
// A plain character goes through the row, adjust, base and write states;
// opening a new line also blanks each of its cells, and a row left beyond a
// shrunken ring is first reduced by the remainder unit. A word flush prints
// each held byte in turn plus any line blanking. A read fetches its cell from
// the store, an out-of-ring read gives an invalid zero cell, a clear blanks
// the store. One item at a time; reset restores registers and cursor only.
// ----------------------------------------------------------------------------
module text_console_wrap_writer #(
  parameter int TEXT_SIZE = tcw_pkg::TEXT_SIZE_DEF,
  parameter int MAX_COLS  = tcw_pkg::MAX_COLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  tcw_in_if.sink                    in_ch,
  tcw_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [tcw_pkg::CFGI_W-1:0] cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]  cfg_wdata
);
  import tcw_pkg::*;

  // Store address width and held-word sizes. The store size is a power of
  // two, so the row base wraps by keeping the low address bits.
  localparam int AW  = $clog2(TEXT_SIZE);
  localparam int HW  = $clog2(MAX_COLS);
  localparam int CW  = $clog2(MAX_COLS + 1);

  // Configuration registers.
  logic [LW_W-1:0]   line_width_r;
  logic [TL_W-1:0]   total_lines_r;
  logic [CELL_W-1:0] or_mask_r;

  // Console state.
  state_t            state_r, state_nxt;
  state_t            ret_r;
  flush_cont_t       fc_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [COL_W-1:0]  cursor_r;
  logic              rp_r;
  logic              color_r;
  logic              start_r;
  logic              boundary_r;
  logic [CW-1:0]     count_r;

  // Working registers of the sequencer.
  logic [CHAR_W-1:0] item_char_r;
  logic              last_r;
  logic [ROW_W-1:0]  back_r;
  logic [COL_W-1:0]  col_r;
  logic [CHAR_W-1:0] pc_char_r;
  logic              from_flush_r;
  logic [ROW_W-1:0]  r_r;
  logic [AW-1:0]     base_r;
  logic              clr_line_r;
  logic [COL_W-1:0]  lidx_r;
  logic [CW-1:0]     fl_idx_r;
  logic [AW-1:0]     fill_r;

  // Result register.
  logic              out_valid_r;
  logic [CELL_W-1:0] out_value_r;
  logic              out_cv_r;

  // Memory and remainder unit controls.
  logic              txt_we;
  logic [AW-1:0]     txt_waddr, txt_raddr;
  logic [CELL_W-1:0] txt_wdata, txt_rdata;
  logic              hold_we;
  logic [HW-1:0]     hold_waddr, hold_raddr;
  logic [CHAR_W-1:0] hold_rdata;
  logic              mod_start;
  logic              mod_done;
  logic [TL_W-1:0]   mod_rem;

  // Effective register values, saturated to their legal ranges.
  logic [LW_W-1:0]   w;
  logic [TL_W-1:0]   t;

  always_comb begin
    w = line_width_r;
    if (w == '0) w = LW_W'(1);
    if (w > LW_W'(MAX_COLS)) w = LW_W'(MAX_COLS);
    t = total_lines_r;
    if (t == '0) t = TL_W'(1);
    if (t > TL_W'(RING_MAX)) t = TL_W'(RING_MAX);
  end

  // Cell address: row base plus column, folded back into the store once.
  function automatic logic [AW-1:0] cell_addr(logic [AW-1:0] b, logic [COL_W-1:0] c);
    logic [AW:0] s;
    s = {1'b0, b} + (AW+1)'(c);
    if (s >= (AW+1)'(TEXT_SIZE)) s = s - (AW+1)'(TEXT_SIZE);
    return s[AW-1:0];
  endfunction

  // Shared decode terms.
  logic              acc;
  logic              in_consume;
  logic              in_delim;
  logic              can_load;
  logic              row_fits;
  logic              rd_ok;
  logic [CW:0]       hold_cnt_nx;
  logic              hold_full;
  logic              fl_last;
  logic              fl_end;
  logic              cursor_over;
  logic              cursor_wrap;
  logic [9:0]        fl_sum;

  assign acc         = in_ch.valid && in_ch.ready;
  assign in_consume  = start_r && (in_ch.char_code == CH_COLOR1 ||
                                   in_ch.char_code == CH_COLOR2);
  assign in_delim    = in_ch.char_code <= CH_SPACE;
  assign can_load    = !out_valid_r || out_ch.ready;
  assign row_fits    = {1'b0, cur_row_r} < t;
  assign rd_ok       = ({1'b0, back_r} < t) && ({1'b0, col_r} < w);
  assign hold_cnt_nx = (count_r < CW'(MAX_COLS)) ? {1'b0, count_r} + 1'b1
                                                  : {1'b0, count_r};
  assign hold_full   = (10'(hold_cnt_nx) >= 10'(w)) || (hold_cnt_nx >= (CW+1)'(MAX_COLS));
  assign fl_last     = ({1'b0, fl_idx_r} + 1'b1) >= {1'b0, count_r};
  // A flush is over when nothing is held or the last held byte went out.
  assign fl_end      = (state_r == S_FL_START && count_r == '0) ||
                       (state_r == S_FL_NEXT && fl_last);
  assign cursor_over = {1'b0, cursor_r} >= w;
  assign cursor_wrap = ({1'b0, cursor_r} + 1'b1) >= w;
  assign fl_sum      = 10'(cursor_r) + 10'(count_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (cmd_t'(in_ch.cmd))
            CMD_WRITE: begin
              if (in_consume)                         state_nxt = S_POST;
              else if (in_delim)                      state_nxt = S_FL_START;
              else if (boundary_r || count_r != '0)   state_nxt = S_HOLD;
              else                                    state_nxt = S_ROWMOD;
            end
            CMD_READ:  state_nxt = S_RD_START;
            CMD_CLEAR: state_nxt = S_CLR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ROWMOD:   state_nxt = row_fits ? ret_r : S_MODW;
      S_MODW:     if (mod_done) state_nxt = ret_r;
      S_MUL:      state_nxt = ret_r;
      S_PC_ADJ:   state_nxt = S_MUL;
      S_PC_BASE:  state_nxt = clr_line_r ? S_PC_CLR : S_PC_CHAR;
      S_PC_CLR:   if ({1'b0, lidx_r} == w - 1'b1) state_nxt = S_PC_CHAR;
      S_PC_CHAR:  state_nxt = from_flush_r ? S_FL_NEXT : S_POST;
      S_FL_START, S_FL_NEXT: begin
        if (fl_end) begin
          case (fc_r)
            FC_PUT:  state_nxt = S_ROWMOD;
            FC_POST: state_nxt = S_POST;
            default: state_nxt = S_IDLE;
          endcase
        end else begin
          state_nxt = S_FL_RD;
        end
      end
      S_FL_RD:    state_nxt = S_FL_GET;
      S_FL_GET:   state_nxt = S_ROWMOD;
      S_HOLD:     state_nxt = hold_full ? S_FL_START : S_POST;
      S_POST:     state_nxt = last_r ? S_FL_START : S_IDLE;
      S_RD_START: begin
        if (!rd_ok) begin
          if (!out_valid_r) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ROWMOD;
        end
      end
      S_RD_ROW:   state_nxt = S_MUL;
      S_RD_ADDR:  if (can_load) state_nxt = S_RD_DATA;
      S_RD_DATA:  state_nxt = S_IDLE;
      S_CLR:      if (fill_r == AW'(TEXT_SIZE - 1)) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Memory, remainder unit and handshake controls.
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    txt_we      = 1'b0;
    txt_waddr   = cell_addr(base_r, cursor_r);
    txt_wdata   = ({1'b0, pc_char_r} | {color_r, 8'h00}) | or_mask_r;
    txt_raddr   = cell_addr(base_r, col_r);
    hold_we     = 1'b0;
    hold_waddr  = count_r[HW-1:0];
    hold_raddr  = fl_idx_r[HW-1:0];
    mod_start   = 1'b0;
    case (state_r)
      S_ROWMOD: mod_start = !row_fits;
      S_PC_CLR: begin
        txt_we    = 1'b1;
        txt_waddr = cell_addr(base_r, lidx_r);
        txt_wdata = CELL_W'(CH_SPACE);
      end
      S_PC_CHAR: txt_we = (pc_char_r != CH_NL) && (pc_char_r != CH_CR);
      S_HOLD:    hold_we = count_r < CW'(MAX_COLS);
      S_CLR: begin
        txt_we    = 1'b1;
        txt_waddr = fill_r;
        txt_wdata = CELL_W'(CH_SPACE);
      end
      default: ;
    endcase
  end

  // Configuration registers; software must write them only while the block is
  // idle. The block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r  <= LW_RST;
      total_lines_r <= TL_RST;
      or_mask_r     <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_LINE_WIDTH:  line_width_r  <= cfg_wdata[LW_W-1:0];
        REG_TOTAL_LINES: total_lines_r <= cfg_wdata[TL_W-1:0];
        REG_OR_MASK:     or_mask_r     <= cfg_wdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer datapath. Each state reads, modifies and writes back the
  // console state; the text store is touched one cell per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      fc_r         <= FC_DONE;
      cur_row_r    <= ROW_RST;
      cursor_r     <= '0;
      rp_r         <= 1'b0;
      color_r      <= 1'b0;
      start_r      <= 1'b1;
      boundary_r   <= 1'b1;
      count_r      <= '0;
      last_r       <= 1'b0;
      from_flush_r <= 1'b0;
      clr_line_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (acc) begin
            item_char_r <= in_ch.char_code;
            back_r      <= in_ch.line_back;
            col_r       <= in_ch.column;
            fill_r      <= '0;
            case (cmd_t'(in_ch.cmd))
              CMD_WRITE: begin
                last_r <= in_ch.last_of_message;
                // The first byte of a message may be the color marker.
                if (start_r) begin
                  start_r <= 1'b0;
                  color_r <= in_consume;
                end
                if (!in_consume) begin
                  if (in_delim) begin
                    fc_r       <= FC_PUT;
                    boundary_r <= 1'b1;
                  end else if (boundary_r) begin
                    boundary_r <= 1'b0;
                  end else if (count_r == '0) begin
                    pc_char_r    <= in_ch.char_code;
                    from_flush_r <= 1'b0;
                    ret_r        <= S_PC_ADJ;
                  end
                end
              end
              CMD_READ: ret_r <= S_RD_ROW;
              default: ;
            endcase
          end
        end
        S_ROWMOD: begin
          if (row_fits) r_r <= cur_row_r;
        end
        S_MODW: begin
          if (mod_done) r_r <= mod_rem[ROW_W-1:0];
        end
        S_MUL: begin : row_base
          logic [PROD_W-1:0] prod;
          prod   = PROD_W'(r_r) * PROD_W'(w);
          base_r <= prod[AW-1:0];
        end
        S_PC_ADJ: begin : pc_adj
          logic [TL_W-1:0] r0;
          logic [TL_W-1:0] r1;
          logic            nl;
          r0 = {1'b0, r_r};
          // A pending carriage return steps back onto the line it ended.
          if (rp_r) r0 = (r_r == '0) ? t - 1'b1 : r0 - 1'b1;
          nl = cursor_over || (cursor_r == '0);
          r1 = r0;
          if (nl) r1 = (r0 + 1'b1 == t) ? '0 : r0 + 1'b1;
          if (cursor_over) cursor_r <= '0;
          rp_r       <= 1'b0;
          clr_line_r <= nl;
          r_r        <= r1[ROW_W-1:0];
          cur_row_r  <= r1[ROW_W-1:0];
          ret_r      <= S_PC_BASE;
          lidx_r     <= '0;
        end
        S_PC_CLR: lidx_r <= lidx_r + 1'b1;
        S_PC_CHAR: begin
          if (pc_char_r == CH_NL) begin
            cursor_r <= '0;
          end else if (pc_char_r == CH_CR) begin
            cursor_r <= '0;
            rp_r     <= 1'b1;
          end else begin
            cursor_r <= cursor_wrap ? '0 : cursor_r + 1'b1;
          end
        end
        S_FL_START: begin
          // A word that fits on a line but not in what is left of this one
          // starts on a fresh line.
          if (count_r != '0 && 10'(count_r) < 10'(w) && fl_sum > 10'(w)) begin
            cursor_r <= '0;
          end
          fl_idx_r <= '0;
        end
        S_FL_NEXT: begin
          if (fl_last) count_r <= '0;
          else fl_idx_r <= fl_idx_r + 1'b1;
        end
        S_FL_GET: begin
          pc_char_r    <= hold_rdata;
          from_flush_r <= 1'b1;
          ret_r        <= S_PC_ADJ;
        end
        S_HOLD: begin
          count_r <= hold_cnt_nx[CW-1:0];
          fc_r    <= FC_POST;
        end
        S_POST: begin
          if (last_r) begin
            last_r     <= 1'b0;
            start_r    <= 1'b1;
            boundary_r <= 1'b1;
            fc_r       <= FC_DONE;
          end
        end
        S_RD_START: begin
          if (!rd_ok && !out_valid_r) begin
            out_valid_r <= 1'b1;
            out_value_r <= '0;
            out_cv_r    <= 1'b0;
          end
        end
        S_RD_ROW: begin : rd_row
          logic [TL_W:0] s;
          s = {2'b00, r_r} + {1'b0, t} - {2'b00, back_r};
          if (s >= {1'b0, t}) s = s - {1'b0, t};
          r_r   <= s[ROW_W-1:0];
          ret_r <= S_RD_ADDR;
        end
        S_RD_DATA: begin
          out_valid_r <= 1'b1;
          out_value_r <= txt_rdata;
          out_cv_r    <= 1'b1;
        end
        S_CLR: fill_r <= fill_r + 1'b1;
        default: ;
      endcase

      // Leaving a flush that continues with the delimiter character.
      if (fl_end && fc_r == FC_PUT) begin
        pc_char_r    <= item_char_r;
        from_flush_r <= 1'b0;
        ret_r        <= S_PC_ADJ;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_value = out_value_r;
  assign out_ch.cell_valid = out_cv_r;

  tcw_ram #(.WIDTH(CELL_W), .DEPTH(TEXT_SIZE)) u_text_ram (
    .clk   (clk),
    .we    (txt_we),
    .waddr (txt_waddr),
    .wdata (txt_wdata),
    .raddr (txt_raddr),
    .rdata (txt_rdata)
  );

  tcw_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_COLS)) u_hold_ram (
    .clk   (clk),
    .we    (hold_we),
    .waddr (hold_waddr),
    .wdata (item_char_r),
    .raddr (hold_raddr),
    .rdata (hold_rdata)
  );

  // Reduces a row left beyond the ring after total_lines shrinks.
  tcw_mod #(.NW(ROW_W), .DVW(TL_W)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (cur_row_r),
    .divisor  (t),
    .done     (mod_done),
    .rem      (mod_rem)
  );

endmodule

// ===== sim/tb_text_console_wrap_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console wrap writer testbench
// Drives character, read, clear and unused commands through the input channel
// and checks every returned cell against a directed row or a behavioral model
// of the console kept in this bench. A directed table comes first. Random
// messages, reads and noise follow over register settings and idling phases.
// ----------------------------------------------------------------------------
module tb_text_console_wrap_writer;
  import tcw_pkg::*;

  localparam int STORE_CELLS = 16384;
  localparam int HOLD_MAX    = 256;
  localparam int IDLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS = 60;
  localparam int SETTLE      = 100;

  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic              ok;
  } cell_t;

  // One row of the directed table. When typed is set, the cell expected from
  // a read is given in the row itself instead of by the console model.
  typedef struct {
    cmd_t              op;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [ROW_W-1:0]  back;
    logic [COL_W-1:0]  col;
    bit                typed;
    cell_t             want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFGI_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_wrap_writer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Console model: registers, cursor state, word buffer and the cell store.
  // --------------------------------------------------------------------------
  logic [LW_W-1:0]   width_reg;
  logic [TL_W-1:0]   lines_reg;
  logic [CELL_W-1:0] mask_reg;
  logic [CELL_W-1:0] cells [STORE_CELLS];
  int unsigned row_now, col_now, word_len;
  bit ret_pending, color_on, msg_start, word_edge;
  logic [CHAR_W-1:0] word_buf [HOLD_MAX];

  cell_t expected_cells [$];
  int errors = 0;
  int reads_checked = 0;
  int writes_sent = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_req = 0;

  function automatic int unsigned width_used();
    int unsigned w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > HOLD_MAX) w = HOLD_MAX;
    return w;
  endfunction

  function automatic int unsigned lines_used();
    int unsigned t;
    t = lines_reg;
    if (t < 1) t = 1;
    if (t > RING_MAX) t = RING_MAX;
    return t;
  endfunction

  function automatic int unsigned cell_index(int unsigned r, int unsigned c);
    return (r * width_used() + c) % STORE_CELLS;
  endfunction

  function automatic void model_reset();
    width_reg = LW_RST;
    lines_reg = TL_RST;
    mask_reg = '0;
    foreach (cells[i]) cells[i] = '0;
    row_now = lines_used() - 1;
    col_now = 0;
    word_len = 0;
    ret_pending = 0;
    color_on = 0;
    msg_start = 1;
    word_edge = 1;
  endfunction

  // Places one character at the cursor, opening a fresh blank line first
  // whenever the cursor sits at column zero.
  function automatic void place_char(logic [CHAR_W-1:0] c);
    int unsigned w, t, r;
    w = width_used();
    t = lines_used();
    r = row_now % t;
    if (ret_pending) begin
      r = (r + t - 1) % t;
      ret_pending = 0;
    end
    if (col_now >= w) col_now = 0;
    if (col_now == 0) begin
      r = (r + 1) % t;
      for (int unsigned i = 0; i < w; i++) cells[cell_index(r, i)] = {1'b0, CH_SPACE};
    end
    row_now = r;
    if (c == CH_NL) begin
      col_now = 0;
    end else if (c == CH_CR) begin
      col_now = 0;
      ret_pending = 1;
    end else begin
      cells[cell_index(r, col_now)] = {color_on, c} | mask_reg;
      col_now++;
      if (col_now >= w) col_now = 0;
    end
  endfunction

  // A held word that fits on a line but not in the rest of this one moves
  // to a new line before it is printed.
  function automatic void flush_word();
    int unsigned w;
    w = width_used();
    if (word_len == 0) return;
    if (word_len < w && col_now + word_len > w) col_now = 0;
    for (int unsigned i = 0; i < word_len; i++) place_char(word_buf[i]);
    word_len = 0;
  endfunction

  function automatic void hold_char(logic [CHAR_W-1:0] c);
    if (word_len < HOLD_MAX) begin
      word_buf[word_len] = c;
      word_len++;
    end
    if (word_len >= width_used()) flush_word();
  endfunction

  function automatic void model_write(logic [CHAR_W-1:0] c, logic last);
    bit eaten;
    eaten = 0;
    if (msg_start) begin
      msg_start = 0;
      color_on = (c == CH_COLOR1 || c == CH_COLOR2);
      eaten = color_on;
    end
    if (!eaten) begin
      if (c <= CH_SPACE) begin
        flush_word();
        word_edge = 1;
        place_char(c);
      end else if (word_edge) begin
        word_edge = 0;
        hold_char(c);
      end else if (word_len > 0) begin
        hold_char(c);
      end else begin
        place_char(c);
      end
    end
    if (last) begin
      flush_word();
      msg_start = 1;
      word_edge = 1;
    end
  endfunction

  function automatic cell_t model_read(logic [ROW_W-1:0] back, logic [COL_W-1:0] col);
    int unsigned t, w, r;
    cell_t res;
    t = lines_used();
    w = width_used();
    res = '0;
    if (back < t && col < w) begin
      r = ((row_now % t) + t - back) % t;
      res.value = cells[cell_index(r, col)];
      res.ok = 1'b1;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver. Gaps lower valid; otherwise valid stays high from one
  // transfer to the next. The model is updated when a transfer happens.
  // --------------------------------------------------------------------------
  task automatic send_op(cmd_t op, logic [CHAR_W-1:0] ch, logic last,
                         logic [ROW_W-1:0] back, logic [COL_W-1:0] col,
                         bit typed = 0, cell_t typed_cell = '0);
    cell_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= op;
    in_ch.char_code       <= ch;
    in_ch.last_of_message <= last;
    in_ch.line_back       <= back;
    in_ch.column          <= col;
    do @(posedge clk); while (!in_ch.ready);
    case (op)
      CMD_WRITE: begin
        model_write(ch, last);
        writes_sent++;
      end
      CMD_READ: begin
        got = model_read(back, col);
        expected_cells.push_back(typed ? typed_cell : got);
      end
      CMD_CLEAR: begin
        foreach (cells[i]) cells[i] = {1'b0, CH_SPACE};
      end
      default: ;
    endcase
  endtask

  task automatic rest_channel();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // A read issued last returns only after every earlier item is finished,
  // so once it is back the block is idle and registers may be changed.
  task automatic drain();
    send_op(CMD_READ, '0, 1'b0, '0, '0);
    rest_channel();
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LINE_WIDTH:  width_reg = data[LW_W-1:0];
      REG_TOTAL_LINES: lines_reg = data[TL_W-1:0];
      REG_OR_MASK:     mask_reg  = data[CELL_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CHAR_W-1:0] word_char();
    if ($urandom_range(99) < 80) return CHAR_W'($urandom_range(8'h61, 8'h7A));
    return CHAR_W'($urandom_range(8'h21, 8'hFF));
  endfunction

  function automatic logic [CHAR_W-1:0] gap_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return CH_SPACE;
    if (pick < 85) return CH_NL;
    if (pick < 95) return CH_CR;
    return CHAR_W'($urandom_range(0, 8'h20));
  endfunction

  // A well-formed message: optional color marker, words split by delimiters,
  // mostly short words and now and then one longer than a line.
  task automatic send_message(ref int sent);
    int unsigned words, len;
    if ($urandom_range(3) == 0) begin
      send_op(CMD_WRITE, ($urandom_range(1) ? CH_COLOR1 : CH_COLOR2), 1'b0, '0, '0);
      sent++;
    end
    words = $urandom_range(1, 5);
    for (int unsigned k = 0; k < words; k++) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 10);
      for (int unsigned j = 0; j < len; j++) begin
        send_op(CMD_WRITE, word_char(),
                (k == words - 1 && j == len - 1 && $urandom_range(3) != 0), '0, '0);
        sent++;
      end
      if (k != words - 1 || $urandom_range(1)) begin
        send_op(CMD_WRITE, gap_char(), (k == words - 1), '0, '0);
        sent++;
      end
    end
    // Make sure the message really ends so the held word is flushed.
    if (!msg_start) begin
      send_op(CMD_WRITE, gap_char(), 1'b1, '0, '0);
      sent++;
    end
  endtask

  task automatic send_read();
    logic [ROW_W-1:0] back;
    logic [COL_W-1:0] col;
    if ($urandom_range(9) == 0) back = ROW_W'($urandom);
    else back = ROW_W'($urandom_range(0, 12));
    if ($urandom_range(1)) col = COL_W'($urandom);
    else col = COL_W'($urandom_range(0, 40));
    send_op(CMD_READ, '0, 1'b0, back, col);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when the main flow asks.
  // --------------------------------------------------------------------------
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_off_req != 0) begin
      hold_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every returned cell is checked against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected cell: actual value %h valid %b",
                 $time, out_ch.cell_value, out_ch.cell_valid);
        errors++;
      end else begin
        cell_t want;
        want = expected_cells.pop_front();
        reads_checked++;
        if (out_ch.cell_value !== want.value)
          begin
          $display("%0t: cell_value mismatch: expected %h actual %h",
                   $time, want.value, out_ch.cell_value);
          errors++;
        end
        if (out_ch.cell_valid !== want.ok) begin
          $display("%0t: cell_valid mismatch: expected %b actual %b",
                   $time, want.ok, out_ch.cell_valid);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on either channel for
  // too long, while reset is released.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_text_console_wrap_writer: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main flow.
  // --------------------------------------------------------------------------
  row_t plan [$];
  logic [CFG_W-1:0] settings [6][3];

  initial begin
    int sent;
    in_ch.valid           = 1'b0;
    in_ch.cmd             = CMD_NONE;
    in_ch.char_code       = '0;
    in_ch.last_of_message = 1'b0;
    in_ch.line_back       = '0;
    in_ch.column          = '0;
    out_ch.ready          = 1'b0;
    model_reset();

    // The clear must come first: the store is undefined until then.
    plan = '{
      '{CMD_CLEAR, 8'h00, 1'b0, 14'd0,     8'd0,   1'b0, '0},
      '{CMD_READ,  8'h00, 1'b0, 14'd0,     8'd0,   1'b1, '{9'h020, 1'b1}},
      '{CMD_READ,  8'h00, 1'b0, 14'd16383, 8'd0,   1'b1, '{9'h000, 1'b0}},
      '{CMD_READ,  8'h00, 1'b0, 14'd0,     8'd255, 1'b1, '{9'h000, 1'b0}},
      '{CMD_WRITE, CH_COLOR1, 1'b0, 14'd0, 8'd0,   1'b0, '0},
      '{CMD_WRITE, 8'h48, 1'b0, 14'd0,     8'd0,   1'b0, '0},
      '{CMD_WRITE, 8'h69, 1'b1, 14'd0,     8'd0,   1'b0, '0},
      '{CMD_READ,  8'h00, 1'b0, 14'd0,     8'd0,   1'b0, '0},
      // A message made of the color marker alone prints nothing.
      '{CMD_WRITE, CH_COLOR2, 1'b1, 14'd0, 8'd0,   1'b0, '0},
      '{CMD_WRITE, CH_NL, 1'b0, 14'd0,     8'd0,   1'b0, '0},
      '{CMD_WRITE, 8'h41, 1'b0, 14'd0,     8'd0,   1'b0, '0},
      '{CMD_WRITE, CH_CR, 1'b0, 14'd0,     8'd0,   1'b0, '0},
      '{CMD_WRITE, 8'h42, 1'b1, 14'd0,     8'd0,   1'b0, '0},
      '{CMD_READ,  8'h00, 1'b0, 14'd0,     8'd0,   1'b0, '0},
      // High bytes are word characters, byte zero is a stored delimiter.
      '{CMD_WRITE, 8'hFF, 1'b0, 14'd0,     8'd0,   1'b0, '0},
      '{CMD_WRITE, 8'h80, 1'b0, 14'd0,     8'd0,   1'b0, '0},
      '{CMD_WRITE, 8'h00, 1'b1, 14'd0,     8'd0,   1'b0, '0},
      '{CMD_READ,  8'h00, 1'b0, 14'd1,     8'd0,   1'b0, '0},
      '{CMD_READ,  8'h00, 1'b0, 14'd0,     8'd1,   1'b0, '0},
      '{CMD_NONE,  8'h78, 1'b1, 14'd5,     8'd3,   1'b0, '0},
      '{CMD_READ,  8'h00, 1'b0, 14'd430,   8'd37,  1'b0, '0},
      '{CMD_READ,  8'h00, 1'b0, 14'd431,   8'd0,   1'b1, '{9'h000, 1'b0}}
    };

    // Register settings per random phase: width, ring lines, or-mask. The
    // extremes of each field are among them, out of range too, but zero lines.
    settings[0] = '{15'd38,  15'd431,   15'd0};
    settings[1] = '{15'd256, 15'd16384, 15'd256};
    settings[2] = '{15'd0,   15'd1,     15'd511};
    settings[3] = '{15'd511, 15'd32767, 15'd0};
    settings[4] = '{15'd40,  15'd3,     15'd1};
    settings[5] = '{15'd0, 15'd0, 15'd0};
    settings[5][0] = CFG_W'($urandom_range(38, 256));
    settings[5][1] = CFG_W'($urandom_range(1, 64));
    settings[5][2] = CFG_W'($urandom_range(0, 511));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      send_op(plan[i].op, plan[i].ch, plan[i].last, plan[i].back, plan[i].col,
              plan[i].typed, plan[i].want);
    drain();

    // The unused register index must change nothing.
    write_reg(REG_NONE, CFG_W'($urandom));

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_LINE_WIDTH,  settings[p][0]);
      write_reg(REG_TOTAL_LINES, settings[p][1]);
      write_reg(REG_OR_MASK,     settings[p][2]);
      // Idling phases: none, sender idle 70 %, receiver stalling 70 %, both 6 %.
      send_idle_pct  = (p % 4 == 1) ? 70 : (p % 4 == 3) ? 6 : 0;
      recv_stall_pct = (p % 4 == 2) ? 70 : (p % 4 == 3) ? 6 : 0;
      if (p == 1) begin
        // Long receiver hold-off while reads keep coming, so the block fills
        // and stops accepting input.
        hold_off_req = 3000;
        for (int k = 0; k < 6; k++) send_read();
      end
      if (p == 3) send_op(CMD_CLEAR, '0, 1'b0, '0, '0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
          send_message(sent);
        end else if (pick < 85) begin
          send_read();
          sent++;
        end else begin
          // Noise: stray bytes with random end flags, and the unused command.
          send_op($urandom_range(3) == 0 ? CMD_NONE : CMD_WRITE,
                  CHAR_W'($urandom), 1'($urandom), ROW_W'($urandom), COL_W'($urandom));
          sent++;
        end
        if ($urandom_range(2) == 0) send_read();
      end
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d character writes and %0d checked reads over six register settings",
             writes_sent, reads_checked);
    $display("with free-running, sender-idle, receiver-stall and mixed handshake phases.");
    if (errors == 0) begin
      $display("tb_text_console_wrap_writer: PASS");
    end else begin
      $display("tb_text_console_wrap_writer: FAIL");
    end
    $finish;
  end

endmodule
